// ----- design/rycc_pkg.sv -----
// ----------------------------------------------------------------------------
// rycc_pkg
// Shared types and register indexes of the RGB / YCbCr colour converter.
// ----------------------------------------------------------------------------
package rycc_pkg;

    localparam int PIX_W = 8;

    // configuration register indexes
    localparam logic CFG_IDX_STANDARD  = 1'b0;
    localparam logic CFG_IDX_DIRECTION = 1'b1;

    // luma standard codes
    localparam logic STD_BT601 = 1'b0;
    localparam logic STD_BT709 = 1'b1;

    // direction codes
    localparam logic DIR_TO_YCBCR = 1'b0;
    localparam logic DIR_TO_RGB   = 1'b1;

    // control that travels with an item through a datapath
    typedef struct packed {
        logic vld;
        logic std;
    } t_ctl;

endpackage

// ----- design/rgb_ycbcr_converter_top.sv -----
// ----------------------------------------------------------------------------
// rgb_ycbcr_converter_top
// Full-range RGB <-> YCbCr pixel converter, BT.601 or BT.709 weights.
// ----------------------------------------------------------------------------
//  channel   direction  signals
//  pixel in  in         start, busy, i_comp_first/second/third
//  pixel out out        o_strobe, o_out_first/second/third
//  config    in         i_cfg_we, i_cfg_idx, i_cfg_wdata
//
//  One item enters per clock while busy is low; each result strobes after its
//  start has passed the input register, three datapath stages and the clamp register.
//  The rate is set by the fully pipelined multiplier stages of both paths.
//  Synchronous active-low reset clears valid bits and config; busy is high
//  while reset is held and for the cycle after it. The receiver cannot
//  stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module rgb_ycbcr_converter_top #(
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic                        i_cfg_wdata,
    input  logic                        start,
    output logic                        busy,
    input  logic [rycc_pkg::PIX_W-1:0]  i_comp_first,
    input  logic [rycc_pkg::PIX_W-1:0]  i_comp_second,
    input  logic [rycc_pkg::PIX_W-1:0]  i_comp_third,
    output logic                        o_strobe,
    output logic [rycc_pkg::PIX_W-1:0]  o_out_first,
    output logic [rycc_pkg::PIX_W-1:0]  o_out_second,
    output logic [rycc_pkg::PIX_W-1:0]  o_out_third
);

    localparam int AW = 2 * COEF_FRAC_BITS + 12;
    localparam int PW = rycc_pkg::PIX_W;

    logic                   r_std, r_dir, r_run;
    logic                   r_in_vld, r_in_std, r_in_dir;
    logic [PW-1:0]          r_in_a, r_in_b, r_in_c;
    rycc_pkg::t_ctl         fwd_ctl, inv_ctl;

    logic                   fwd_vld, inv_vld;
    logic signed [AW-1:0]   fwd_0, fwd_1, fwd_2;
    logic signed [AW-1:0]   inv_0, inv_1, inv_2;
    logic signed [AW-1:0]   acc_0, acc_1, acc_2;

    logic                   r_out_vld;
    logic [PW-1:0]          r_out_0, r_out_1, r_out_2;
    logic                   accept;

    // floor to a byte, negative gives 0, overflow gives 255
    function automatic logic [PW-1:0] f_clamp(input logic signed [AW-1:0] acc);
        logic [PW-1:0] v;
        if (acc[AW-1]) begin
            v = '0;
        end else if (|acc[AW-2:2*COEF_FRAC_BITS+PW]) begin
            v = '1;
        end else begin
            v = acc[2*COEF_FRAC_BITS+PW-1:2*COEF_FRAC_BITS];
        end
        return v;
    endfunction

    assign busy   = ~r_run;
    assign accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_std     <= rycc_pkg::STD_BT601;
            r_dir     <= rycc_pkg::DIR_TO_YCBCR;
            r_run     <= 1'b0;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_run <= 1'b1;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rycc_pkg::CFG_IDX_STANDARD:  r_std <= i_cfg_wdata;
                    rycc_pkg::CFG_IDX_DIRECTION: r_dir <= i_cfg_wdata;
                    default: ;
                endcase
            end
            r_in_vld  <= accept;
            r_out_vld <= fwd_vld | inv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_std <= r_std;
        r_in_dir <= r_dir;
        r_in_a   <= i_comp_first;
        r_in_b   <= i_comp_second;
        r_in_c   <= i_comp_third;
        r_out_0  <= f_clamp(acc_0);
        r_out_1  <= f_clamp(acc_1);
        r_out_2  <= f_clamp(acc_2);
    end

    // steer each item into the path of its direction
    assign fwd_ctl.vld = r_in_vld & (r_in_dir == rycc_pkg::DIR_TO_YCBCR);
    assign fwd_ctl.std = r_in_std;
    assign inv_ctl.vld = r_in_vld & (r_in_dir == rycc_pkg::DIR_TO_RGB);
    assign inv_ctl.std = r_in_std;

    rycc_fwd #(
        .FRAC   (COEF_FRAC_BITS)
    ) u_fwd (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (fwd_ctl),
        .i_a    (r_in_a),
        .i_b    (r_in_b),
        .i_c    (r_in_c),
        .o_vld  (fwd_vld),
        .o_y    (fwd_0),
        .o_cb   (fwd_1),
        .o_cr   (fwd_2)
    );

    rycc_inv #(
        .FRAC   (COEF_FRAC_BITS)
    ) u_inv (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (inv_ctl),
        .i_a    (r_in_a),
        .i_b    (r_in_b),
        .i_c    (r_in_c),
        .o_vld  (inv_vld),
        .o_r    (inv_0),
        .o_g    (inv_1),
        .o_b    (inv_2)
    );

    assign acc_0 = fwd_vld ? fwd_0 : inv_0;
    assign acc_1 = fwd_vld ? fwd_1 : inv_1;
    assign acc_2 = fwd_vld ? fwd_2 : inv_2;

    assign o_strobe     = r_out_vld;
    assign o_out_first  = r_out_0;
    assign o_out_second = r_out_1;
    assign o_out_third  = r_out_2;

`ifndef SYNTH
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##5 o_strobe)
        else $error("accepted item did not strobe out after five cycles");

    a_one_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fwd_vld && inv_vld))
        else $error("both datapaths delivered in the same cycle");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("strobe raised straight after reset");
`endif

endmodule

// ----- design/rycc_fwd.sv -----
// ----------------------------------------------------------------------------
// rycc_fwd
// RGB to YCbCr datapath: three stages (weights, luma and differences,
// chroma scaling). Results leave as accumulators with 2*FRAC fraction bits.
// ----------------------------------------------------------------------------
module rycc_fwd #(
    parameter int FRAC = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rycc_pkg::t_ctl                  i_ctl,
    input  logic [rycc_pkg::PIX_W-1:0]      i_a,
    input  logic [rycc_pkg::PIX_W-1:0]      i_b,
    input  logic [rycc_pkg::PIX_W-1:0]      i_c,
    output logic                            o_vld,
    output logic signed [2*FRAC+11:0]       o_y,
    output logic signed [2*FRAC+11:0]       o_cb,
    output logic signed [2*FRAC+11:0]       o_cr
);

    localparam int     AW  = 2 * FRAC + 12;
    localparam int     PW  = FRAC + rycc_pkg::PIX_W;
    localparam int     DW  = PW + 1;
    localparam longint ONE = longint'(1) << FRAC;

    localparam longint KR601_L = (299 * ONE + 500) / 1000;
    localparam longint KB601_L = (114 * ONE + 500) / 1000;
    localparam longint KR709_L = (2126 * ONE + 5000) / 10000;
    localparam longint KB709_L = (722 * ONE + 5000) / 10000;

    localparam logic [FRAC-1:0] KR601 = FRAC'(KR601_L);
    localparam logic [FRAC-1:0] KB601 = FRAC'(KB601_L);
    localparam logic [FRAC-1:0] KG601 = FRAC'(ONE - KR601_L - KB601_L);
    localparam logic [FRAC-1:0] KR709 = FRAC'(KR709_L);
    localparam logic [FRAC-1:0] KB709 = FRAC'(KB709_L);
    localparam logic [FRAC-1:0] KG709 = FRAC'(ONE - KR709_L - KB709_L);

    localparam logic signed [FRAC:0] CBS601 = (FRAC+1)'((1000 * ONE + 886) / 1772);
    localparam logic signed [FRAC:0] CRS601 = (FRAC+1)'((1000 * ONE + 701) / 1402);
    localparam logic signed [FRAC:0] CBS709 = (FRAC+1)'((10000 * ONE + 9278) / 18556);
    localparam logic signed [FRAC:0] CRS709 = (FRAC+1)'((10000 * ONE + 7874) / 15748);

    // 127.5 at 2*FRAC fraction bits
    localparam logic signed [AW-1:0] HALF2 = AW'(longint'(255) << (2 * FRAC - 1));

    // stage A: weighted components
    rycc_pkg::t_ctl                 r_a_ctl;
    logic [PW-1:0]                  r_a_pr, r_a_pg, r_a_pb;
    logic [rycc_pkg::PIX_W-1:0]     r_a_a, r_a_c;
    logic [FRAC-1:0]                kr, kg, kb;

    // stage B: luma and colour differences
    rycc_pkg::t_ctl                 r_b_ctl;
    logic [PW-1:0]                  r_b_y;
    logic signed [DW-1:0]           r_b_db, r_b_dr;
    logic [PW-1:0]                  n_b_y;

    // stage C: scaled chroma
    logic                           r_c_vld;
    logic signed [AW-1:0]           r_c_y, r_c_cb, r_c_cr;
    logic signed [FRAC:0]           cbs, crs;

    assign kr  = (i_ctl.std == rycc_pkg::STD_BT709) ? KR709 : KR601;
    assign kg  = (i_ctl.std == rycc_pkg::STD_BT709) ? KG709 : KG601;
    assign kb  = (i_ctl.std == rycc_pkg::STD_BT709) ? KB709 : KB601;
    assign cbs = (r_b_ctl.std == rycc_pkg::STD_BT709) ? CBS709 : CBS601;
    assign crs = (r_b_ctl.std == rycc_pkg::STD_BT709) ? CRS709 : CRS601;

    assign n_b_y = r_a_pr + r_a_pg + r_a_pb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
            r_b_ctl <= '0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_ctl <= i_ctl;
            r_b_ctl <= r_a_ctl;
            r_c_vld <= r_b_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_pr <= PW'(kr * i_a);
        r_a_pg <= PW'(kg * i_b);
        r_a_pb <= PW'(kb * i_c);
        r_a_a  <= i_a;
        r_a_c  <= i_c;

        r_b_y  <= n_b_y;
        r_b_db <= $signed({1'b0, r_a_c, {FRAC{1'b0}}}) - $signed({1'b0, n_b_y});
        r_b_dr <= $signed({1'b0, r_a_a, {FRAC{1'b0}}}) - $signed({1'b0, n_b_y});

        r_c_y  <= $signed({{(AW-PW-FRAC){1'b0}}, r_b_y, {FRAC{1'b0}}});
        r_c_cb <= r_b_db * cbs + HALF2;
        r_c_cr <= r_b_dr * crs + HALF2;
    end

    assign o_vld = r_c_vld;
    assign o_y   = r_c_y;
    assign o_cb  = r_c_cb;
    assign o_cr  = r_c_cr;

endmodule

// ----- design/rycc_inv.sv -----
// ----------------------------------------------------------------------------
// rycc_inv
// YCbCr to RGB datapath: three stages (offset removal, matrix products,
// sums). Results leave as accumulators with 2*FRAC fraction bits.
// ----------------------------------------------------------------------------
module rycc_inv #(
    parameter int FRAC = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rycc_pkg::t_ctl                  i_ctl,
    input  logic [rycc_pkg::PIX_W-1:0]      i_a,
    input  logic [rycc_pkg::PIX_W-1:0]      i_b,
    input  logic [rycc_pkg::PIX_W-1:0]      i_c,
    output logic                            o_vld,
    output logic signed [2*FRAC+11:0]       o_r,
    output logic signed [2*FRAC+11:0]       o_g,
    output logic signed [2*FRAC+11:0]       o_b
);

    localparam int     AW  = 2 * FRAC + 12;
    localparam int     DW  = FRAC + rycc_pkg::PIX_W + 1;
    localparam int     CW  = FRAC + 2;
    localparam longint ONE = longint'(1) << FRAC;

    localparam logic signed [CW-1:0] RCR601 = CW'((1402 * ONE + 500) / 1000);
    localparam logic signed [CW-1:0] BCB601 = CW'((1772 * ONE + 500) / 1000);
    localparam logic signed [CW-1:0] GCB601 = CW'((202008 * ONE + 293500) / 587000);
    localparam logic signed [CW-1:0] GCR601 = CW'((419198 * ONE + 293500) / 587000);
    localparam logic signed [CW-1:0] RCR709 = CW'((15748 * ONE + 5000) / 10000);
    localparam logic signed [CW-1:0] BCB709 = CW'((18556 * ONE + 5000) / 10000);
    localparam logic signed [CW-1:0] GCB709 =
        CW'((13397432 * ONE + 35760000) / 71520000);
    localparam logic signed [CW-1:0] GCR709 =
        CW'((33480248 * ONE + 35760000) / 71520000);

    // 127.5 at FRAC fraction bits
    localparam logic signed [DW-1:0] HALF1 = DW'(longint'(255) << (FRAC - 1));

    // stage A: offsets removed
    rycc_pkg::t_ctl                 r_a_ctl;
    logic [rycc_pkg::PIX_W-1:0]     r_a_y;
    logic signed [DW-1:0]           r_a_cbf, r_a_crf;

    // stage B: matrix products
    logic                           r_b_vld;
    logic [rycc_pkg::PIX_W-1:0]     r_b_y;
    logic signed [AW-1:0]           r_b_rcr, r_b_gcb, r_b_gcr, r_b_bcb;
    logic signed [CW-1:0]           rcr, gcb, gcr, bcb;

    // stage C: channel sums
    logic                           r_c_vld;
    logic signed [AW-1:0]           r_c_r, r_c_g, r_c_b;
    logic signed [AW-1:0]           yf;

    assign rcr = (r_a_ctl.std == rycc_pkg::STD_BT709) ? RCR709 : RCR601;
    assign bcb = (r_a_ctl.std == rycc_pkg::STD_BT709) ? BCB709 : BCB601;
    assign gcb = (r_a_ctl.std == rycc_pkg::STD_BT709) ? GCB709 : GCB601;
    assign gcr = (r_a_ctl.std == rycc_pkg::STD_BT709) ? GCR709 : GCR601;

    assign yf = $signed({{(AW-rycc_pkg::PIX_W-2*FRAC){1'b0}}, r_b_y, {(2*FRAC){1'b0}}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_ctl <= i_ctl;
            r_b_vld <= r_a_ctl.vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_y   <= i_a;
        r_a_cbf <= $signed({1'b0, i_b, {FRAC{1'b0}}}) - HALF1;
        r_a_crf <= $signed({1'b0, i_c, {FRAC{1'b0}}}) - HALF1;

        r_b_y   <= r_a_y;
        r_b_rcr <= r_a_crf * rcr;
        r_b_gcb <= r_a_cbf * gcb;
        r_b_gcr <= r_a_crf * gcr;
        r_b_bcb <= r_a_cbf * bcb;

        r_c_r   <= yf + r_b_rcr;
        r_c_g   <= yf - r_b_gcb - r_b_gcr;
        r_c_b   <= yf + r_b_bcb;
    end

    assign o_vld = r_c_vld;
    assign o_r   = r_c_r;
    assign o_g   = r_c_g;
    assign o_b   = r_c_b;

endmodule
